// ----- hw/rtl/pac_pkg.sv -----
package pac_pkg;

  // Fixed-point format and time base
  localparam int unsigned FracBits       = 16;
  localparam int unsigned TicksPerSecond = 1000000;

  // Configuration register indexes
  localparam int unsigned CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] REG_GAIN_P  = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_GAIN_I  = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_GAIN_D  = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_OUT_MIN = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_OUT_MAX = 3'd4;

  // Input word op codes
  localparam logic OP_STEP    = 1'b0;
  localparam logic OP_RESTART = 1'b1;

  // Reset values of the registers
  localparam logic [30:0]        GainPReset  = 31'd65536;
  localparam logic signed [31:0] OutMaxReset = 32'sd6553600;

  // Integral magnitudes are capped at 2^62
  localparam logic [63:0] Cap62 = 64'h4000_0000_0000_0000;

  // Operation run on the shared multiply-divide unit
  typedef enum logic [2:0] {
    OP_LIMIT = 3'd0,
    OP_P     = 3'd1,
    OP_EDT   = 3'd2,
    OP_I     = 3'd3,
    OP_D1    = 3'd4,
    OP_D2    = 3'd5,
    OP_CORR  = 3'd6
  } pac_op_e;

  // Controller to datapath
  typedef struct packed {
    logic    load_item;
    logic    restart;
    logic    start;
    logic    capture;
    logic    sum;
    logic    load_out;
    pac_op_e op;
  } pac_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic dirty;
    logic first;
    logic sat;
    logic unit_done;
    logic out_busy;
  } pac_status_t;

  // Signed saturation of a magnitude with a sign to 32 bits
  function automatic logic signed [31:0] sat_mag(input logic neg, input logic [63:0] m);
    logic signed [31:0] r;
    if (neg) begin
      if (m >= 64'h8000_0000) r = 32'sh8000_0000;
      else r = 32'(0 - m[31:0]);
    end else begin
      if (m >= 64'h7FFF_FFFF) r = 32'sh7FFF_FFFF;
      else r = 32'(m[31:0]);
    end
    return r;
  endfunction

endpackage

// ----- hw/rtl/pac_muldiv.sv -----
module pac_muldiv (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] a_i,
  input  logic [63:0] b_i,
  input  logic [63:0] d_i,
  output logic        done_o,
  output logic [63:0] q_o
);

  typedef enum logic [2:0] {
    MD_IDLE = 3'b001,
    MD_MUL  = 3'b010,
    MD_DIV  = 3'b100
  } md_state_e;

  md_state_e state_q, state_d;
  logic [63:0]  a_q, b_q, d_q;
  logic [127:0] prod_q, prod_d;
  logic [5:0]   cnt_q, cnt_d;
  logic         done_q, done_d;

  // One 32x32 partial product per cycle
  logic [31:0]  pa, pb;
  logic [63:0]  pp;
  logic [6:0]   sh;
  logic [127:0] prod_add;
  assign pa = cnt_q[0] ? a_q[63:32] : a_q[31:0];
  assign pb = cnt_q[1] ? b_q[63:32] : b_q[31:0];
  assign pp = pa * pb;
  assign sh = 7'({1'b0, cnt_q[0]} + {1'b0, cnt_q[1]}) << 5;
  assign prod_add = prod_q + (128'(pp) << sh);

  // Restoring divide, one quotient bit per cycle
  logic [64:0]  rext, rsub;
  logic         ge;
  logic [63:0]  newr;
  logic [127:0] prod_div;
  assign rext = {prod_q[127:64], prod_q[63]};
  assign ge   = rext >= {1'b0, d_q};
  assign rsub = rext - {1'b0, d_q};
  assign newr = ge ? rsub[63:0] : rext[63:0];
  assign prod_div = {newr, prod_q[62:0], ge};

  always_comb begin
    state_d = state_q;
    prod_d  = prod_q;
    cnt_d   = cnt_q;
    done_d  = 1'b0;
    unique case (state_q)
      MD_IDLE: begin
        if (start_i) begin
          prod_d  = '0;
          cnt_d   = '0;
          state_d = MD_MUL;
        end
      end
      MD_MUL: begin
        cnt_d = cnt_q + 6'd1;
        if (cnt_q[1:0] == 2'd3) begin
          if (d_q == 64'd0 || prod_add[127:64] >= d_q) begin
            prod_d  = {prod_add[127:64], {64{1'b1}}};
            done_d  = 1'b1;
            state_d = MD_IDLE;
          end else if (d_q == 64'd1) begin
            prod_d  = prod_add;
            done_d  = 1'b1;
            state_d = MD_IDLE;
          end else begin
            prod_d  = prod_add;
            cnt_d   = '0;
            state_d = MD_DIV;
          end
        end else begin
          prod_d = prod_add;
        end
      end
      MD_DIV: begin
        prod_d = prod_div;
        cnt_d  = cnt_q + 6'd1;
        if (cnt_q == 6'd63) begin
          done_d  = 1'b1;
          state_d = MD_IDLE;
        end
      end
      default: state_d = MD_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= MD_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  // Operands and working register
  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    if (state_q == MD_IDLE && start_i) begin
      a_q <= a_i;
      b_q <= b_i;
      d_q <= d_i;
    end
  end

  assign done_o = done_q;
  assign q_o    = prod_q[63:0];

endmodule

// ----- hw/rtl/pac_datapath.sv -----
module pac_datapath (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  pac_pkg::pac_cmd_t              cmd_i,
  output pac_pkg::pac_status_t           status_o,
  input  logic                           cfg_we_i,
  input  logic [pac_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [31:0]                    cfg_data_i,
  input  logic signed [31:0]             setpoint_i,
  input  logic signed [31:0]             measured_i,
  input  logic [31:0]                    timestamp_i,
  input  logic                           out_stall_i,
  output logic                           out_valid_o,
  output logic signed [31:0]             drive_o,
  output logic signed [31:0]             p_term_o,
  output logic signed [31:0]             i_term_o,
  output logic signed [31:0]             d_term_o,
  output logic                           saturated_o
);

  // Registers
  logic [30:0]        gain_p_q, gain_i_q, gain_d_q;
  logic signed [31:0] out_min_q, out_max_q;
  logic               dirty_q;
  logic [62:0]        lim_q;
  logic signed [63:0] acc_q;
  logic signed [31:0] prev_err_q;
  logic [31:0]        prev_time_q;
  logic               first_q;
  logic signed [31:0] err_q, p_q, i_q, d_q;
  logic [31:0]        ts_q, dt_q;
  logic [63:0]        x_q;
  logic signed [33:0] raw_q;
  logic signed [31:0] drive_q;
  logic               out_valid_q;
  logic signed [31:0] drive_out_q, p_out_q, i_out_q, d_out_q;
  logic               sat_out_q;

  // Shared multiply-divide unit
  logic [63:0] md_a, md_b, md_d, md_q;
  logic        md_done;

  pac_muldiv u_muldiv (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(cmd_i.start),
    .a_i    (md_a),
    .b_i    (md_b),
    .d_i    (md_d),
    .done_o (md_done),
    .q_o    (md_q)
  );

  // Derived values
  logic [63:0]        ki_eff, tps;
  logic signed [32:0] rng, de, err_full;
  logic signed [31:0] err_in;
  logic [31:0]        err_mag, diff, dt_in;
  logic [32:0]        de_mag;
  logic [63:0]        acc_mag;
  logic signed [34:0] ex;
  logic [34:0]        ex_mag;
  logic signed [33:0] raw_now;
  logic signed [31:0] drive_now;

  assign ki_eff  = (gain_i_q == 31'd0) ? 64'd1 : 64'(gain_i_q);
  assign tps     = 64'(pac_pkg::TicksPerSecond);
  assign rng     = 33'(out_max_q) - 33'(out_min_q);
  assign err_mag = err_q[31] ? (32'd0 - err_q) : err_q;
  assign de      = 33'(err_q) - 33'(prev_err_q);
  assign de_mag  = de[32] ? (33'd0 - de) : de;
  assign acc_mag = acc_q[63] ? (64'd0 - acc_q) : acc_q;
  assign ex      = 35'(raw_q) - 35'(drive_q);
  assign ex_mag  = ex[34] ? (35'd0 - ex) : ex;

  // Error and tick step of an incoming word
  assign err_full = 33'(setpoint_i) - 33'(measured_i);
  assign err_in = (err_full > 33'sh0_7FFF_FFFF) ? 32'sh7FFF_FFFF :
                  (err_full < -33'sh0_8000_0000) ? 32'sh8000_0000 : 32'(err_full);
  assign diff  = timestamp_i - prev_time_q;
  assign dt_in = (!first_q && diff != 32'd0 && !diff[31]) ? diff : 32'd1;

  // Raw sum and clamp to output limits
  assign raw_now = 34'(p_q) + 34'(i_q) + 34'(d_q);
  always_comb begin
    if (raw_now < 34'(out_min_q)) drive_now = out_min_q;
    else if (raw_now > 34'(out_max_q)) drive_now = out_max_q;
    else drive_now = 32'(raw_now);
  end

  // Operand selection for the shared unit
  always_comb begin
    md_a = '0;
    md_b = '0;
    md_d = 64'd1;
    unique case (cmd_i.op)
      pac_pkg::OP_LIMIT: begin
        md_a = 64'(unsigned'(rng)) << pac_pkg::FracBits;
        md_b = tps;
        md_d = ki_eff;
      end
      pac_pkg::OP_P: begin
        // plain product, the fraction bits are shifted out on capture
        md_a = 64'(gain_p_q);
        md_b = 64'(err_mag);
      end
      pac_pkg::OP_EDT: begin
        md_a = 64'(err_mag);
        md_b = 64'(dt_q);
      end
      pac_pkg::OP_I: begin
        md_a = 64'(gain_i_q);
        md_b = acc_mag;
        md_d = tps << pac_pkg::FracBits;
      end
      pac_pkg::OP_D1: begin
        md_a = 64'(gain_d_q);
        md_b = 64'(de_mag);
      end
      pac_pkg::OP_D2: begin
        md_a = x_q;
        md_b = tps;
        md_d = 64'(dt_q) << pac_pkg::FracBits;
      end
      pac_pkg::OP_CORR: begin
        md_a = 64'(ex_mag) << pac_pkg::FracBits;
        md_b = tps;
        md_d = ki_eff;
      end
      default: md_a = '0;
    endcase
  end

  // Integral clamp to +-limit
  function automatic logic signed [63:0] clamp_acc(input logic signed [65:0] v,
                                                   input logic [62:0] lim);
    logic signed [65:0] ls;
    logic signed [63:0] r;
    ls = $signed({3'b000, lim});
    if (v < -ls) r = 64'(-ls);
    else if (v > ls) r = 64'(ls);
    else r = 64'(v);
    return r;
  endfunction

  logic [63:0]        q_cap;
  logic signed [65:0] edt_s, corr_s;
  assign q_cap  = (md_q > pac_pkg::Cap62) ? pac_pkg::Cap62 : md_q;
  assign edt_s  = 66'(acc_q) + (err_q[31] ? -66'(md_q) : 66'(md_q));
  assign corr_s = 66'(acc_q) - (ex[34] ? -66'(q_cap) : 66'(q_cap));

  // Configuration registers and controller state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_p_q    <= pac_pkg::GainPReset;
      gain_i_q    <= '0;
      gain_d_q    <= '0;
      out_min_q   <= '0;
      out_max_q   <= pac_pkg::OutMaxReset;
      dirty_q     <= 1'b1;
      lim_q       <= '0;
      acc_q       <= '0;
      prev_err_q  <= '0;
      prev_time_q <= '0;
      first_q     <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          pac_pkg::REG_GAIN_P:  begin gain_p_q  <= cfg_data_i[30:0]; dirty_q <= 1'b1; end
          pac_pkg::REG_GAIN_I:  begin gain_i_q  <= cfg_data_i[30:0]; dirty_q <= 1'b1; end
          pac_pkg::REG_GAIN_D:  begin gain_d_q  <= cfg_data_i[30:0]; dirty_q <= 1'b1; end
          pac_pkg::REG_OUT_MIN: begin out_min_q <= cfg_data_i;       dirty_q <= 1'b1; end
          pac_pkg::REG_OUT_MAX: begin out_max_q <= cfg_data_i;       dirty_q <= 1'b1; end
          default: ;
        endcase
      end
      if (cmd_i.restart) begin
        acc_q       <= '0;
        prev_err_q  <= '0;
        prev_time_q <= '0;
        first_q     <= 1'b1;
      end
      if (cmd_i.capture) begin
        unique case (cmd_i.op)
          pac_pkg::OP_LIMIT: begin
            dirty_q <= 1'b0;
            lim_q   <= (rng <= 33'sd0) ? 63'd0 : q_cap[62:0];
          end
          pac_pkg::OP_EDT:  acc_q <= clamp_acc(edt_s, lim_q);
          pac_pkg::OP_CORR: acc_q <= clamp_acc(corr_s, lim_q);
          default: ;
        endcase
      end
      if (cmd_i.sum) begin
        prev_err_q  <= err_q;
        prev_time_q <= ts_q;
        first_q     <= 1'b0;
      end
      if (cmd_i.load_out) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  // Per-step working registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      err_q <= err_in;
      ts_q  <= timestamp_i;
      dt_q  <= dt_in;
      d_q   <= '0;
    end
    if (cmd_i.capture) begin
      unique case (cmd_i.op)
        pac_pkg::OP_P:  p_q <= pac_pkg::sat_mag(err_q[31], md_q >> pac_pkg::FracBits);
        pac_pkg::OP_I:  i_q <= pac_pkg::sat_mag(acc_q[63], md_q);
        pac_pkg::OP_D1: x_q <= md_q;
        pac_pkg::OP_D2: d_q <= pac_pkg::sat_mag(de[32], md_q);
        default: ;
      endcase
    end
    if (cmd_i.sum) begin
      raw_q   <= raw_now;
      drive_q <= drive_now;
    end
    if (cmd_i.load_out) begin
      drive_out_q <= drive_q;
      p_out_q     <= p_q;
      i_out_q     <= i_q;
      d_out_q     <= d_q;
      sat_out_q   <= (raw_q != 34'(drive_q));
    end
  end

  assign status_o.dirty     = dirty_q;
  assign status_o.first     = first_q;
  assign status_o.sat       = (raw_now != 34'(drive_now));
  assign status_o.unit_done = md_done;
  assign status_o.out_busy  = out_valid_q & out_stall_i;

  assign out_valid_o = out_valid_q;
  assign drive_o     = drive_out_q;
  assign p_term_o    = p_out_q;
  assign i_term_o    = i_out_q;
  assign d_term_o    = d_out_q;
  assign saturated_o = sat_out_q;

endmodule

// ----- hw/rtl/pac_ctrl.sv -----
module pac_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 op_i,
  output logic                 in_stall_o,
  input  pac_pkg::pac_status_t status_i,
  output pac_pkg::pac_cmd_t    cmd_o
);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_ISSUE = 5'b00010,
    ST_WAIT  = 5'b00100,
    ST_SUM   = 5'b01000,
    ST_FIN   = 5'b10000
  } ctrl_state_e;

  ctrl_state_e     state_q, state_d;
  pac_pkg::pac_op_e op_q, op_d;

  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    cmd_o   = '{load_item: 1'b0, restart: 1'b0, start: 1'b0, capture: 1'b0,
                sum: 1'b0, load_out: 1'b0, op: op_q};
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (op_i == pac_pkg::OP_RESTART) begin
            cmd_o.restart = 1'b1;
          end else begin
            cmd_o.load_item = 1'b1;
            op_d    = status_i.dirty ? pac_pkg::OP_LIMIT : pac_pkg::OP_P;
            state_d = ST_ISSUE;
          end
        end
      end
      ST_ISSUE: begin
        cmd_o.start = 1'b1;
        state_d     = ST_WAIT;
      end
      ST_WAIT: begin
        if (status_i.unit_done) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_ISSUE;
          unique case (op_q)
            pac_pkg::OP_LIMIT: op_d = pac_pkg::OP_P;
            pac_pkg::OP_P:     op_d = pac_pkg::OP_EDT;
            pac_pkg::OP_EDT:   op_d = pac_pkg::OP_I;
            pac_pkg::OP_I: begin
              if (status_i.first) state_d = ST_SUM;
              else op_d = pac_pkg::OP_D1;
            end
            pac_pkg::OP_D1:    op_d = pac_pkg::OP_D2;
            pac_pkg::OP_D2:    state_d = ST_SUM;
            pac_pkg::OP_CORR:  state_d = ST_FIN;
            default:           state_d = ST_IDLE;
          endcase
        end
      end
      ST_SUM: begin
        cmd_o.sum = 1'b1;
        if (status_i.sat) begin
          op_d    = pac_pkg::OP_CORR;
          state_d = ST_ISSUE;
        end else begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!status_i.out_busy) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      op_q    <= pac_pkg::OP_P;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
    end
  end

  assign in_stall_o = (state_q != ST_IDLE);

endmodule

// ----- hw/rtl/pid_antiwindup_controller.sv -----
// Channel | Direction | Handshake              | Word
// input   | in        | in_valid_i/in_stall_o  | op_i, setpoint_i, measured_i, timestamp_i
// output  | out       | out_valid_o/out_stall_i| drive_o, p_term_o, i_term_o, d_term_o,
//         |           |                        |   saturated_o
// config  | in        | cfg_we_i               | cfg_idx_i, cfg_data_i
//
// A step word passes through the shared multiply-divide unit once per operation before its result:
// each pass is a plain product, or a product with a restoring divide (I term, D term, limit after
// a register write, anti-windup); a first step skips the D term, and a quotient that overflows or
// a divisor of one skips its divide.
// A restart word is taken without leaving the idle state and gives no result.
// Reset is asynchronous, active low; the integral limit is rebuilt on the next step.
// A result waits in the output register; the next word is taken meanwhile.
module pid_antiwindup_controller (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [pac_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [31:0]                  cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         op_i,
  input  logic signed [31:0]           setpoint_i,
  input  logic signed [31:0]           measured_i,
  input  logic [31:0]                  timestamp_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic signed [31:0]           drive_o,
  output logic signed [31:0]           p_term_o,
  output logic signed [31:0]           i_term_o,
  output logic signed [31:0]           d_term_o,
  output logic                         saturated_o
);

  pac_pkg::pac_cmd_t    cmd;
  pac_pkg::pac_status_t status;

  pac_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .op_i      (op_i),
    .in_stall_o(in_stall_o),
    .status_i  (status),
    .cmd_o     (cmd)
  );

  pac_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .status_o   (status),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .setpoint_i (setpoint_i),
    .measured_i (measured_i),
    .timestamp_i(timestamp_i),
    .out_stall_i(out_stall_i),
    .out_valid_o(out_valid_o),
    .drive_o    (drive_o),
    .p_term_o   (p_term_o),
    .i_term_o   (i_term_o),
    .d_term_o   (d_term_o),
    .saturated_o(saturated_o)
  );

endmodule
